### hw/rtl/sled_pkg.sv
// Shared types, character codes and helper functions of the string literal
// escape decoder. No dependencies; sled_core and the top level use it.
package sled_pkg;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  // Scanner modes
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_BODY   = 3'd1,
    MODE_ESC    = 3'd2,
    MODE_CR     = 3'd3,
    MODE_HEX    = 3'd4,
    MODE_CLOSE  = 3'd5,
    MODE_UFIRST = 3'd6
  } mode_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_CHAR   = 3'd0,
    ST_CLOSED = 3'd1,
    ST_UNTERM = 3'd2,
    ST_BADHEX = 3'd3,
    ST_BRACE  = 3'd4,
    ST_ENDED  = 3'd5,
    ST_TOOBIG = 3'd6
  } status_e;

  localparam int unsigned CharW   = 16;
  localparam int unsigned DigitsW = 3;

  // Character codes
  localparam logic [CharW-1:0] CH_LF     = 16'h000A;
  localparam logic [CharW-1:0] CH_CR     = 16'h000D;
  localparam logic [CharW-1:0] CH_BSLASH = 16'h005C;
  localparam logic [CharW-1:0] CH_LBRACE = 16'h007B;
  localparam logic [CharW-1:0] CH_RBRACE = 16'h007D;
  localparam logic [CharW-1:0] CH_ZERO   = 16'h0030;
  localparam logic [CharW-1:0] CH_B      = 16'h0062;
  localparam logic [CharW-1:0] CH_F      = 16'h0066;
  localparam logic [CharW-1:0] CH_N      = 16'h006E;
  localparam logic [CharW-1:0] CH_R      = 16'h0072;
  localparam logic [CharW-1:0] CH_T      = 16'h0074;
  localparam logic [CharW-1:0] CH_V      = 16'h0076;
  localparam logic [CharW-1:0] CH_X      = 16'h0078;
  localparam logic [CharW-1:0] CH_U      = 16'h0075;
  localparam logic [CharW-1:0] CH_LS     = 16'h2028;
  localparam logic [CharW-1:0] CH_PS     = 16'h2029;
  localparam logic [CharW-1:0] BYTE_MAX  = 16'h00FF;

  // Control characters that simple escapes stand for
  localparam logic [CharW-1:0] CH_NUL = 16'h0000;
  localparam logic [CharW-1:0] CH_BS  = 16'h0008;
  localparam logic [CharW-1:0] CH_FF  = 16'h000C;
  localparam logic [CharW-1:0] CH_HT  = 16'h0009;
  localparam logic [CharW-1:0] CH_VT  = 16'h000B;

  typedef struct packed {
    logic [CharW-1:0] decoded_char;
    status_e          status;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  typedef struct packed {
    logic             to_esc;
    logic             emit;
    status_e          status;
    logic [CharW-1:0] ch;
  } body_t;

  // Decode one hex digit
  function automatic hex_t hex_value(logic [CharW-1:0] c);
    hex_t r;
    r.ok    = 1'b1;
    r.value = c[3:0];
    if (c inside {[16'h0030:16'h0039]}) begin
      r.value = c[3:0];
    end else if ((c inside {[16'h0061:16'h0066]}) || (c inside {[16'h0041:16'h0046]})) begin
      r.value = 4'(c[3:0] + 4'd9);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Handle one ordinary character inside the literal body
  function automatic body_t body_step(logic [CharW-1:0] c, logic [CharW-1:0] quote,
                                      logic eight_bit);
    body_t r;
    logic  wide;
    wide     = !eight_bit && (c == CH_LS || c == CH_PS);
    r.to_esc = 1'b0;
    r.emit   = 1'b1;
    r.status = ST_CHAR;
    r.ch     = c;
    if (c == CH_BSLASH) begin
      r.to_esc = 1'b1;
      r.emit   = 1'b0;
    end else if (c == quote) begin
      r.status = ST_CLOSED;
    end else if (c == CH_LF || c == CH_CR || wide) begin
      r.status = ST_UNTERM;
    end
    return r;
  endfunction

endpackage

### hw/rtl/sled_in_if.sv
// Input channel of the string literal escape decoder: valid/ready plus item.
// Depends on nothing.
interface sled_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] char_code;

  modport source (output valid, output kind, output char_code, input ready);
  modport sink (input valid, input kind, input char_code, output ready);
endinterface

### hw/rtl/sled_out_if.sv
// Result channel of the string literal escape decoder: valid/ready plus item.
// Depends on nothing.
interface sled_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] decoded_char;
  logic [2:0]  status;

  modport source (output valid, output decoded_char, output status, input ready);
  modport sink (input valid, input decoded_char, input status, output ready);
endinterface

### hw/rtl/sled_core.sv
// Scanner state and single-step decode logic of the escape decoder.
// Depends on sled_pkg.
module sled_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [1:0]                      kind_i,
  input  logic [sled_pkg::CharW-1:0]      char_code_i,
  input  logic                            eight_bit_i,
  output logic                            res_valid_o,
  output sled_pkg::res_t                  res_o
);

  sled_pkg::mode_e                   mode_q, mode_d;
  logic [sled_pkg::CharW-1:0]        quote_q, quote_d;
  logic [sled_pkg::CharW-1:0]        acc_q, acc_d;
  logic [sled_pkg::DigitsW-1:0]      digits_q, digits_d;
  logic                              braced_q, braced_d;

  logic                              emit;
  sled_pkg::status_e                 st;
  logic [sled_pkg::CharW-1:0]        ch;
  logic                              do_finish;
  logic [sled_pkg::CharW-1:0]        fin_acc;
  sled_pkg::hex_t                    hex;
  sled_pkg::body_t                   body;
  logic                              wide;
  logic [sled_pkg::CharW-1:0]        acc_shift;
  logic [sled_pkg::DigitsW-1:0]      digits_dec;

  // Classify the current character
  assign hex        = sled_pkg::hex_value(char_code_i);
  assign body       = sled_pkg::body_step(char_code_i, quote_q, eight_bit_i);
  assign wide       = !eight_bit_i && (char_code_i == sled_pkg::CH_LS ||
                                       char_code_i == sled_pkg::CH_PS);
  assign acc_shift  = {acc_q[sled_pkg::CharW-5:0], hex.value};
  assign digits_dec = (digits_q != '0) ? digits_q - 1'b1 : '0;

  // Compute the result of one item
  always_comb begin
    emit      = 1'b0;
    st        = sled_pkg::ST_CHAR;
    ch        = '0;
    do_finish = 1'b0;
    fin_acc   = acc_q;

    case (kind_i)
      sled_pkg::KIND_END: begin
        if (mode_q != sled_pkg::MODE_IDLE) begin
          emit = 1'b1;
          st   = sled_pkg::ST_ENDED;
        end
      end
      sled_pkg::KIND_CHAR: begin
        case (mode_q)
          sled_pkg::MODE_BODY: begin
            emit = body.emit;
            st   = body.status;
            ch   = body.ch;
          end
          sled_pkg::MODE_CR: begin
            if (char_code_i != sled_pkg::CH_LF) begin
              emit = body.emit;
              st   = body.status;
              ch   = body.ch;
            end
          end
          sled_pkg::MODE_ESC: begin
            emit = 1'b1;
            ch   = char_code_i;
            case (char_code_i)
              sled_pkg::CH_ZERO: ch = sled_pkg::CH_NUL;
              sled_pkg::CH_B:    ch = sled_pkg::CH_BS;
              sled_pkg::CH_F:    ch = sled_pkg::CH_FF;
              sled_pkg::CH_N:    ch = sled_pkg::CH_LF;
              sled_pkg::CH_R:    ch = sled_pkg::CH_CR;
              sled_pkg::CH_T:    ch = sled_pkg::CH_HT;
              sled_pkg::CH_V:    ch = sled_pkg::CH_VT;
              sled_pkg::CH_X:    emit = 1'b0;
              sled_pkg::CH_U:    emit = 1'b0;
              sled_pkg::CH_CR:   emit = 1'b0;
              sled_pkg::CH_LF:   emit = 1'b0;
              default: begin
                if (wide) emit = 1'b0;
              end
            endcase
          end
          sled_pkg::MODE_UFIRST: begin
            if (char_code_i != sled_pkg::CH_LBRACE && !hex.ok) begin
              emit = 1'b1;
              st   = sled_pkg::ST_BADHEX;
            end
          end
          sled_pkg::MODE_HEX: begin
            if (braced_q && char_code_i == sled_pkg::CH_RBRACE) begin
              do_finish = 1'b1;
              fin_acc   = acc_q;
            end else if (!hex.ok) begin
              emit = 1'b1;
              st   = sled_pkg::ST_BADHEX;
            end else if (digits_dec == '0 && !braced_q) begin
              do_finish = 1'b1;
              fin_acc   = acc_shift;
            end
          end
          sled_pkg::MODE_CLOSE: begin
            if (char_code_i == sled_pkg::CH_RBRACE) begin
              do_finish = 1'b1;
              fin_acc   = acc_q;
            end else begin
              emit = 1'b1;
              st   = sled_pkg::ST_BRACE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // Finish a hex escape: range check in 8-bit mode
    if (do_finish) begin
      emit = 1'b1;
      if (eight_bit_i && fin_acc > sled_pkg::BYTE_MAX) begin
        st = sled_pkg::ST_TOOBIG;
      end else begin
        st = sled_pkg::ST_CHAR;
        ch = fin_acc;
      end
    end
  end

  // Compute the next scanner state
  always_comb begin
    mode_d   = mode_q;
    quote_d  = quote_q;
    acc_d    = acc_q;
    digits_d = digits_q;
    braced_d = braced_q;

    case (kind_i)
      sled_pkg::KIND_START: begin
        quote_d  = char_code_i;
        mode_d   = sled_pkg::MODE_BODY;
        acc_d    = '0;
        digits_d = '0;
        braced_d = 1'b0;
      end
      sled_pkg::KIND_CHAR: begin
        case (mode_q)
          sled_pkg::MODE_BODY: begin
            if (body.to_esc) mode_d = sled_pkg::MODE_ESC;
          end
          sled_pkg::MODE_CR: begin
            mode_d = sled_pkg::MODE_BODY;
            if (char_code_i != sled_pkg::CH_LF && body.to_esc) mode_d = sled_pkg::MODE_ESC;
          end
          sled_pkg::MODE_ESC: begin
            mode_d = sled_pkg::MODE_BODY;
            case (char_code_i)
              sled_pkg::CH_X: begin
                acc_d    = '0;
                digits_d = sled_pkg::DigitsW'(2);
                braced_d = 1'b0;
                mode_d   = sled_pkg::MODE_HEX;
              end
              sled_pkg::CH_U: begin
                acc_d  = '0;
                mode_d = sled_pkg::MODE_UFIRST;
              end
              sled_pkg::CH_CR: mode_d = sled_pkg::MODE_CR;
              default: ;
            endcase
          end
          sled_pkg::MODE_UFIRST: begin
            if (char_code_i == sled_pkg::CH_LBRACE) begin
              braced_d = 1'b1;
              digits_d = sled_pkg::DigitsW'(4);
              acc_d    = '0;
              mode_d   = sled_pkg::MODE_HEX;
            end else if (hex.ok) begin
              braced_d = 1'b0;
              digits_d = sled_pkg::DigitsW'(3);
              acc_d    = {{(sled_pkg::CharW-4){1'b0}}, hex.value};
              mode_d   = sled_pkg::MODE_HEX;
            end
          end
          sled_pkg::MODE_HEX: begin
            if (!(braced_q && char_code_i == sled_pkg::CH_RBRACE) && hex.ok) begin
              acc_d    = acc_shift;
              digits_d = digits_dec;
              if (digits_dec == '0 && braced_q) mode_d = sled_pkg::MODE_CLOSE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // A finished escape returns to the body
    if (do_finish && st == sled_pkg::ST_CHAR) mode_d = sled_pkg::MODE_BODY;

    // Any closing or error result drops back to idle
    if (emit && st != sled_pkg::ST_CHAR) mode_d = sled_pkg::MODE_IDLE;
  end

  assign res_valid_o       = step_i && emit;
  assign res_o.status      = st;
  assign res_o.decoded_char = (st == sled_pkg::ST_CHAR) ? ch : '0;

  // Advance scanner state on each stepped item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= sled_pkg::MODE_IDLE;
      quote_q  <= '0;
      acc_q    <= '0;
      digits_q <= '0;
      braced_q <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      quote_q  <= quote_d;
      acc_q    <= acc_d;
      digits_q <= digits_d;
      braced_q <= braced_d;
    end
  end

  // A start item always opens the body
  a_start_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && kind_i == sled_pkg::KIND_START |=> mode_q == sled_pkg::MODE_BODY)
    else $error("start item did not open the literal body");

  // Nothing is produced while no literal is open
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && mode_q == sled_pkg::MODE_IDLE |-> !res_valid_o)
    else $error("result produced while idle");

  // A closing or error result leaves the scanner idle
  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != sled_pkg::ST_CHAR |=> mode_q == sled_pkg::MODE_IDLE)
    else $error("scanner not idle after terminal result");

endmodule

### hw/rtl/string_literal_escape_decoder.sv
// Top level of the string literal escape decoder: input register, scanner
// core and result register. Depends on sled_pkg, sled_in_if, sled_out_if, sled_core.
//
// Usage:
//   in_chan carries items (kind, char_code): kind 0 opens a literal and names
//   its quote, kind 1 is the next character, kind 2 marks end of input.
//   out_chan carries results (decoded_char, status); each item gives at most
//   one result. cfg_valid_i/cfg_data_i write eight_bit_mode (cfg_ready_o is
//   always high); write it only while no item is in flight.
//   Throughput: one item per cycle while the result register is empty or
//   out_chan.ready is high, set by the scanner step between the input
//   register and the result register. A result is captured in the result
//   register when the scanner steps its item out of the input register.
//   Reset clears the scanner to idle, eight_bit_mode to 0 and both registers
//   to empty.
//   When the receiver holds out_chan.ready low, the result register holds,
//   the input register fills, and then in_chan.ready drops until the result
//   is taken; no item or result is lost.
module string_literal_escape_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  sled_in_if.sink     in_chan,
  sled_out_if.source  out_chan,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  logic                          eight_bit_q;
  logic                          in_valid_q;
  logic [1:0]                    in_kind_q;
  logic [sled_pkg::CharW-1:0]    in_code_q;
  logic                          out_valid_q;
  sled_pkg::res_t                out_res_q;
  logic                          advance;
  logic                          step;
  logic                          in_ready;
  logic                          core_valid;
  sled_pkg::res_t                core_res;

  // Configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eight_bit_q <= 1'b0;
    end else if (cfg_valid_i) begin
      eight_bit_q <= cfg_data_i;
    end
  end

  // Pipeline advances whenever the result register can take a new value
  assign advance        = !out_valid_q || out_chan.ready;
  assign step           = in_valid_q && advance;
  assign in_ready       = !in_valid_q || advance;
  assign in_chan.ready  = in_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_chan.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_chan.valid) begin
      in_kind_q <= in_chan.kind;
      in_code_q <= in_chan.char_code;
    end
  end

  sled_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .kind_i      (in_kind_q),
    .char_code_i (in_code_q),
    .eight_bit_i (eight_bit_q),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= core_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && core_valid) begin
      out_res_q <= core_res;
    end
  end

  assign out_chan.valid        = out_valid_q;
  assign out_chan.decoded_char = out_res_q.decoded_char;
  assign out_chan.status       = out_res_q.status;

  // Input side only stalls behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> in_valid_q && out_valid_q && !out_chan.ready)
    else $error("input stalled without a blocked result");

  // A non-character result carries a zero character
  a_zero_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.status != sled_pkg::ST_CHAR |-> out_res_q.decoded_char == '0)
    else $error("terminal result carries a character");

  // A stepped item leaves the input register unless a new one replaces it
  a_step_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !in_chan.valid |=> !in_valid_q)
    else $error("input register kept a consumed item");

endmodule
